@@ rtl/mdm_pkg.sv @@
// mdm_pkg: shared types and constants for the mecanum drive mixer
// request and result payload structs, divider side-band structs
// no dependencies; used by mdm_pdiv and mecanum_drive_mixer
package mdm_pkg;

  localparam int unsigned AXIS_W    = 8;
  localparam int unsigned MOTOR_W   = 16;
  localparam int unsigned LIM_W     = 7;
  localparam int unsigned DIV_STEPS = 4;

  localparam logic [LIM_W-1:0] LIM_RESET = 7'd100;

  // one stick sample
  typedef struct packed {
    logic signed [AXIS_W-1:0] forward_axis;
    logic signed [AXIS_W-1:0] strafe_axis;
    logic signed [AXIS_W-1:0] turn_axis;
  } in_t;

  // four wheel speeds, percent with fraction bits
  typedef struct packed {
    logic signed [MOTOR_W-1:0] front_left_motor;
    logic signed [MOTOR_W-1:0] back_left_motor;
    logic signed [MOTOR_W-1:0] front_right_motor;
    logic signed [MOTOR_W-1:0] back_right_motor;
  } out_t;

  // carried alongside the mecanum sum normalisation
  typedef struct packed {
    logic signed [AXIS_W-1:0] t;
    logic [LIM_W-1:0]         lim;
    logic                     neg_p;
    logic                     neg_d;
    logic                     r_zero;
  } side1_t;

  // carried alongside the drive limit scaling
  typedef struct packed {
    logic [3:0]       neg;
    logic [LIM_W-1:0] lim;
  } side2_t;

endpackage

@@ rtl/mdm_pdiv.sv @@
// mdm_pdiv: pipelined unsigned restoring divider, several lanes sharing one divisor
// DIV_STEPS quotient bits per register stage; side-band travels with the data
// depends on mdm_pkg
module mdm_pdiv #(
  parameter int unsigned DEN_W  = 9,
  parameter int unsigned QUO_W  = 16,
  parameter int unsigned LANES  = 2,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic [LANES-1:0][DEN_W+QUO_W-1:0]     num_i,
  input  logic [DEN_W-1:0]                      den_i,
  input  logic [SIDE_W-1:0]                     side_i,
  output logic                                  out_valid_o,
  output logic [LANES-1:0][QUO_W-1:0]           quo_o,
  output logic [SIDE_W-1:0]                     side_o
);

  localparam int unsigned AW    = DEN_W + QUO_W;
  localparam int unsigned STEPS = mdm_pkg::DIV_STEPS;
  localparam int unsigned NST   = (QUO_W + STEPS - 1) / STEPS;

  logic                         vld_q  [NST];
  logic                         vld_in [NST];
  logic [LANES-1:0][AW-1:0]     acc_q  [NST];
  logic [LANES-1:0][AW-1:0]     acc_d  [NST];
  logic [LANES-1:0][AW-1:0]     acc_in [NST];
  logic [DEN_W-1:0]             den_q  [NST];
  logic [DEN_W-1:0]             den_in [NST];
  logic [SIDE_W-1:0]            side_q [NST];
  logic [SIDE_W-1:0]            side_in[NST];

  for (genvar g = 0; g < NST; g++) begin : g_stage
    // stage input selection
    if (g == 0) begin : g_first
      assign vld_in[g]  = in_valid_i;
      assign acc_in[g]  = num_i;
      assign den_in[g]  = den_i;
      assign side_in[g] = side_i;
    end else begin : g_next
      assign vld_in[g]  = vld_q[g-1];
      assign acc_in[g]  = acc_q[g-1];
      assign den_in[g]  = den_q[g-1];
      assign side_in[g] = side_q[g-1];
    end

    // shift-subtract steps of this stage, remainder in the top bits
    always_comb begin : step_comb
      logic [LANES-1:0][AW-1:0] acc;
      logic [DEN_W:0]           rem;
      acc = acc_in[g];
      rem = '0;
      for (int i = 0; i < STEPS; i++) begin
        if (g * STEPS + i < QUO_W) begin
          for (int l = 0; l < LANES; l++) begin
            rem = {acc[l][AW-1:QUO_W], acc[l][QUO_W-1]};
            if (rem >= {1'b0, den_in[g]}) begin
              rem    = rem - {1'b0, den_in[g]};
              acc[l] = {rem[DEN_W-1:0], acc[l][QUO_W-2:0], 1'b1};
            end else begin
              acc[l] = {rem[DEN_W-1:0], acc[l][QUO_W-2:0], 1'b0};
            end
          end
        end
      end
      acc_d[g] = acc;
    end

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in[g];
      end
    end

    // payload
    always_ff @(posedge clk_i) begin
      acc_q[g]  <= acc_d[g];
      den_q[g]  <= den_in[g];
      side_q[g] <= side_in[g];
    end
  end

  // outputs from the last stage
  assign out_valid_o = vld_q[NST-1];
  assign side_o      = side_q[NST-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = acc_q[NST-1][l][QUO_W-1:0];
    end
  end

`ifndef SYNTHESIS
  // final remainder must lie below the divisor
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST-1] && den_q[NST-1] != '0) |->
      (acc_q[NST-1][0][AW-1:QUO_W] < den_q[NST-1]) &&
      (acc_q[NST-1][LANES-1][AW-1:QUO_W] < den_q[NST-1]))
    else $error("divider remainder not below divisor");
`endif

endmodule

@@ rtl/mecanum_drive_mixer.sv @@
// mecanum_drive_mixer: top level of the mecanum wheel speed mixer
// mecanum sums, normalisation, turn mixing and drive limit scaling
// depends on mdm_pkg and mdm_pdiv
//
// Usage: present a stick sample on req_i with start high; it is taken at a
// rising edge where busy is low. busy is high only in the first cycle after
// reset, so a new sample may be taken in every cycle.
// Each sample yields one result on res_o, marked by done_o for exactly one
// cycle; the receiver cannot hold results off and none is needed.
// Each sample passes the entry register, the normalisation divider, the turn
// mixing register, the scaling register, the limit divider and the output
// register; both restoring dividers are pipelined with 4 quotient bits per stage.
// Throughput: one sample per cycle while busy is low, results in request order.
// drive_limit is written over cfg_valid_i/cfg_ready_o/cfg_data_i, by the user
// only while no request is in flight; the block does not enforce it. Each
// request carries the value seen at entry. Reset clears all valid bits, sets
// drive_limit to 100; no result is lost or repeated since no stage stalls.
module mecanum_drive_mixer #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  mdm_pkg::in_t                        req_i,
  output logic                                done_o,
  output mdm_pkg::out_t                       res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mdm_pkg::LIM_W-1:0]           cfg_data_i
);

  localparam int unsigned LW   = mdm_pkg::LIM_W;
  localparam int unsigned OW   = mdm_pkg::MOTOR_W;
  localparam int unsigned D1W  = 9;
  localparam int unsigned Q1W  = 8 + FRAC_BITS;
  localparam int unsigned N1W  = D1W + Q1W;
  localparam int unsigned P1W  = 17;
  localparam int unsigned WW   = 10 + FRAC_BITS;
  localparam int unsigned D2W  = 9 + FRAC_BITS;
  localparam int unsigned Q2W  = 7 + FRAC_BITS;
  localparam int unsigned N2W  = D2W + Q2W;
  localparam int unsigned P2W  = D2W + LW;
  localparam int unsigned STEPS = mdm_pkg::DIV_STEPS;
  localparam int unsigned LAT  = 4 + (Q1W + STEPS - 1) / STEPS + (Q2W + STEPS - 1) / STEPS;
  localparam int unsigned S1W  = $bits(mdm_pkg::side1_t);
  localparam int unsigned S2W  = $bits(mdm_pkg::side2_t);

  // configuration register and start-up busy flag
  logic [LW-1:0] lim_q;
  logic          busy_q;
  logic          accept;

  assign busy        = busy_q;
  assign cfg_ready_o = !busy_q;
  assign accept      = start && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q  <= mdm_pkg::LIM_RESET;
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        lim_q <= cfg_data_i;
      end
    end
  end

  // entry stage: mecanum sums and normalisation numerators
  logic                       b_vld_q;
  logic [1:0][N1W-1:0]        b_num_q, b_num_d;
  logic [D1W-1:0]             b_r_q, b_r_d;
  mdm_pkg::side1_t            b_side_q, b_side_d;

  always_comb begin
    logic signed [9:0] p, d;
    logic [7:0]        af, as, mx;
    logic [8:0]        ap, ad;
    logic [P1W-1:0]    prod_p, prod_d;
    p  = 10'(req_i.forward_axis) + 10'(req_i.strafe_axis);
    d  = 10'(req_i.forward_axis) - 10'(req_i.strafe_axis);
    af = req_i.forward_axis[7] ? 8'(-req_i.forward_axis) : 8'(req_i.forward_axis);
    as = req_i.strafe_axis[7] ? 8'(-req_i.strafe_axis) : 8'(req_i.strafe_axis);
    mx = (af > as) ? af : as;
    ap = p[9] ? 9'(-p) : 9'(p);
    ad = d[9] ? 9'(-d) : 9'(d);
    prod_p = P1W'(ap) * P1W'(mx);
    prod_d = P1W'(ad) * P1W'(mx);
    b_num_d[0]      = N1W'(prod_p) << FRAC_BITS;
    b_num_d[1]      = N1W'(prod_d) << FRAC_BITS;
    b_r_d           = 9'(af) + 9'(as);
    b_side_d.t      = req_i.turn_axis;
    b_side_d.lim    = lim_q;
    b_side_d.neg_p  = p[9];
    b_side_d.neg_d  = d[9];
    b_side_d.r_zero = (b_r_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    b_num_q  <= b_num_d;
    b_r_q    <= b_r_d;
    b_side_q <= b_side_d;
  end

  // normalisation divide by |forward|+|strafe|
  logic                 q1_vld;
  logic [1:0][Q1W-1:0]  q1;
  logic [S1W-1:0]       q1_side_raw;
  mdm_pkg::side1_t      q1_side;

  mdm_pdiv #(
    .DEN_W  (D1W),
    .QUO_W  (Q1W),
    .LANES  (2),
    .SIDE_W (S1W)
  ) u_div_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_vld_q),
    .num_i       (b_num_q),
    .den_i       (b_r_q),
    .side_i      (b_side_q),
    .out_valid_o (q1_vld),
    .quo_o       (q1),
    .side_o      (q1_side_raw)
  );

  assign q1_side = mdm_pkg::side1_t'(q1_side_raw);

  // turn mixing into the four wheels
  logic                  c_vld_q;
  logic signed [WW-1:0]  c_w_q [4];
  logic signed [WW-1:0]  c_w_d [4];
  logic [LW-1:0]         c_lim_q;

  always_comb begin
    logic signed [Q1W:0]   pe, de, ps, ds;
    logic signed [WW-1:0]  tsc;
    pe  = signed'({1'b0, q1[0]});
    de  = signed'({1'b0, q1[1]});
    ps  = q1_side.neg_p ? -pe : pe;
    ds  = q1_side.neg_d ? -de : de;
    if (q1_side.r_zero) begin
      ps = '0;
      ds = '0;
    end
    tsc = WW'(q1_side.t) <<< FRAC_BITS;
    c_w_d[0] = WW'(ds) - tsc;
    c_w_d[1] = WW'(ps) - tsc;
    c_w_d[2] = WW'(ps) + tsc;
    c_w_d[3] = WW'(ds) + tsc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= q1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    c_w_q   <= c_w_d;
    c_lim_q <= q1_side.lim;
  end

  // largest of the wheel magnitudes and the scaled limit, and limit-scaled numerators
  logic                 d_vld_q;
  logic [3:0][N2W-1:0]  d_num_q, d_num_d;
  logic [D2W-1:0]       d_m_q, d_m_d;
  mdm_pkg::side2_t      d_side_q, d_side_d;

  always_comb begin
    logic [D2W-1:0] aw [4];
    logic [P2W-1:0] prod;
    d_m_d = D2W'(c_lim_q) << FRAC_BITS;
    for (int i = 0; i < 4; i++) begin
      aw[i] = c_w_q[i][WW-1] ? D2W'(-c_w_q[i]) : D2W'(c_w_q[i]);
      if (aw[i] > d_m_d) begin
        d_m_d = aw[i];
      end
      prod          = P2W'(aw[i]) * P2W'(c_lim_q);
      d_num_d[i]    = N2W'(prod) << FRAC_BITS;
      d_side_d.neg[i] = c_w_q[i][WW-1];
    end
    d_side_d.lim = c_lim_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_num_q  <= d_num_d;
    d_m_q    <= d_m_d;
    d_side_q <= d_side_d;
  end

  // drive limit divide by the largest magnitude, never below the scaled limit
  logic                 q2_vld;
  logic [3:0][Q2W-1:0]  q2;
  logic [S2W-1:0]       q2_side_raw;
  mdm_pkg::side2_t      q2_side;

  mdm_pdiv #(
    .DEN_W  (D2W),
    .QUO_W  (Q2W),
    .LANES  (4),
    .SIDE_W (S2W)
  ) u_div_limit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_vld_q),
    .num_i       (d_num_q),
    .den_i       (d_m_q),
    .side_i      (d_side_q),
    .out_valid_o (q2_vld),
    .quo_o       (q2),
    .side_o      (q2_side_raw)
  );

  assign q2_side = mdm_pkg::side2_t'(q2_side_raw);

  // sign, saturation, zero-limit clearing and output register
  logic                  done_q;
  logic signed [OW-1:0]  out_q [4];
  logic signed [OW-1:0]  out_d [4];
  logic [LW-1:0]         out_lim_q;

  always_comb begin
    logic signed [Q2W:0] qs, val;
    logic signed [31:0]  v32;
    for (int i = 0; i < 4; i++) begin
      qs  = signed'({1'b0, q2[i]});
      val = q2_side.neg[i] ? -qs : qs;
      v32 = 32'(val);
      if (q2_side.lim == '0) begin
        out_d[i] = '0;
      end else if (v32 > 32'sd32767) begin
        out_d[i] = 16'sh7fff;
      end else if (v32 < -32'sd32768) begin
        out_d[i] = 16'sh8000;
      end else begin
        out_d[i] = v32[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= q2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    out_lim_q <= q2_side.lim;
  end

  assign done_o                  = done_q;
  assign res_o.front_left_motor  = out_q[0];
  assign res_o.back_left_motor   = out_q[1];
  assign res_o.front_right_motor = out_q[2];
  assign res_o.back_right_motor  = out_q[3];

  // magnitude bound of a result, limit times the fraction scale
  logic signed [31:0] out_bound;
  assign out_bound = signed'(32'(out_lim_q) << FRAC_BITS);

`ifndef SYNTHESIS
  // every accepted request gives its result a fixed time later
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("result strobe does not match request latency");

  // no result without a request that fixed time earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result strobe with no matching request");

  // no wheel exceeds the drive limit
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |->
      (32'(res_o.front_left_motor) <= out_bound) &&
      (-32'(res_o.front_left_motor) <= out_bound) &&
      (32'(res_o.back_left_motor) <= out_bound) &&
      (-32'(res_o.back_left_motor) <= out_bound) &&
      (32'(res_o.front_right_motor) <= out_bound) &&
      (-32'(res_o.front_right_motor) <= out_bound) &&
      (32'(res_o.back_right_motor) <= out_bound) &&
      (-32'(res_o.back_right_motor) <= out_bound))
    else $error("wheel speed beyond drive limit");

  // zero limit stops every wheel
  a_zero_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_lim_q == '0) |-> (res_o == '0))
    else $error("non-zero wheel speed with zero drive limit");
`endif

endmodule
